[src/sorted_priority_queue_macros.svh]
// Assertion macros for the sorted priority queue.
// Each macro expects clk and rst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define SPQ_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sorted_priority_queue: invariant violated");

// cons must hold in the same cycle as ante
`define SPQ_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: implication violated");

// cons must hold in the cycle after ante
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: next-cycle check violated");

`else

`define SPQ_ASSERT_ALWAYS(label, expr)
`define SPQ_ASSERT_IMPLIES(label, ante, cons)
`define SPQ_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[src/spq_pkg.sv]
package spq_pkg;

    // Queue geometry
    localparam int CAPACITY          = 16;
    localparam int DATA_WIDTH        = 32;
    localparam int COUNT_WIDTH       = $clog2(CAPACITY + 1);

    // Fixed port field widths
    localparam int OPCODE_WIDTH      = 2;
    localparam int FIELD_WIDTH       = 32;
    localparam int COUNT_FIELD_WIDTH = 5;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    // Operation codes; the unused code behaves as a peek
    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } op_t;

    // Insertion carry handed from one cell to the next
    typedef struct packed {
        logic  valid;
        data_t data;
    } carry_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic shift_up;
        logic occupied;
        logic max_first;
    } cell_ctrl_t;

    // True when a belongs behind b under the selected order (signed compare)
    function automatic logic out_of_order(data_t a, data_t b, logic max_first);
        logic res;
        if (max_first)
        begin
            res = (a < b);
        end
        else
        begin
            res = (a > b);
        end
        return res;
    endfunction

    // Stored entry to output field, zero extended or truncated
    function automatic logic [FIELD_WIDTH-1:0] to_field(data_t d);
        logic [63:0] t;
        t = 64'($unsigned(d));
        return t[FIELD_WIDTH-1:0];
    endfunction

    // Input field to stored entry, low DATA_WIDTH bits kept
    function automatic data_t from_field(logic [FIELD_WIDTH-1:0] f);
        logic [63:0] t;
        t = 64'(f);
        return data_t'(t[DATA_WIDTH-1:0]);
    endfunction

endpackage

[src/spq_cell.sv]
module spq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::carry_t     carry_in,
    input  spq_pkg::data_t      next_data,
    output spq_pkg::data_t      data,
    output spq_pkg::carry_t     carry_out
);
    import spq_pkg::*;

    data_t data_reg, data_next;
    logic  carry_valid_reg, carry_valid_next;
    data_t carry_data_reg, carry_data_next;
    logic  carry_behind;

    // Keep the winner of carry vs. held entry, pass the loser on
    always_comb
    begin
        carry_behind     = out_of_order(carry_in.data, data_reg, ctrl.max_first);
        data_next        = data_reg;
        carry_valid_next = 1'b0;
        carry_data_next  = carry_behind ? carry_in.data : data_reg;
        if (carry_in.valid)
        begin
            if (ctrl.occupied)
            begin
                data_next        = carry_behind ? data_reg : carry_in.data;
                carry_valid_next = 1'b1;
            end
            else
            begin
                // first free cell: the carry settles here
                data_next = carry_in.data;
            end
        end
        else if (ctrl.shift_up)
        begin
            data_next = next_data;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        data_reg       <= data_next;
        carry_data_reg <= carry_data_next;
    end

    // Carry valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_valid_reg <= 1'b0;
        end
        else
        begin
            carry_valid_reg <= carry_valid_next;
        end
    end

    assign data            = data_reg;
    assign carry_out.valid = carry_valid_reg;
    assign carry_out.data  = carry_data_reg;

endmodule

[src/sorted_priority_queue.sv]
// Channel   Handshake              Payload
// input     in_valid / in_stall    opcode, value
// output    out_valid / out_stall  head_value, count, error
// config    cfg_valid / cfg_ready  cfg_data (order_max_first)
//
// A push also sends an insertion carry past the entries held before it: the
// carry walks down the cell chain one cell per clock to the first free cell.
// The result is registered in the accept cycle; the next item waits for it to leave.
// Reset empties the queue and selects max-first order; cell contents are undefined.
// in_stall is high while a carry is in flight or a result is held by out_stall.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [spq_pkg::OPCODE_WIDTH-1:0]       opcode,
    input  logic signed [spq_pkg::FIELD_WIDTH-1:0] value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [spq_pkg::FIELD_WIDTH-1:0] head_value,
    output logic [spq_pkg::COUNT_FIELD_WIDTH-1:0]  count,
    output logic                                   error,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic                                   cfg_data
);
    import spq_pkg::*;

    logic                         order_reg;
    logic [COUNT_WIDTH-1:0]       count_reg, count_next, occ_count;
    logic                         out_valid_reg;
    logic [FIELD_WIDTH-1:0]       head_reg, head_next;
    logic [COUNT_FIELD_WIDTH-1:0] out_count_reg;
    logic                         error_reg, error_next;

    data_t                        cell_data [CAPACITY];
    carry_t                       carry_out [CAPACITY];
    carry_t                       carry_head;
    logic [CAPACITY-1:0]          carry_busy;

    logic                         busy, accept, full, empty, shift_up;
    data_t                        item;
    op_t                          op;

    // Handshake
    assign busy      = |carry_busy;
    assign in_stall  = busy || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign item  = from_field($unsigned(value));
    assign op    = op_t'(opcode);
    assign full  = (count_reg == COUNT_WIDTH'(CAPACITY));
    assign empty = (count_reg == '0);

    // While a carry moves, count_reg already includes the new entry
    assign occ_count = busy ? (count_reg - COUNT_WIDTH'(1)) : count_reg;

    // Operation decode and result
    always_comb
    begin
        count_next       = count_reg;
        error_next       = 1'b0;
        head_next        = '0;
        shift_up         = 1'b0;
        carry_head.valid = 1'b0;
        carry_head.data  = item;
        case (op)
            OP_PUSH:
            begin
                if (full)
                begin
                    error_next = 1'b1;
                    head_next  = to_field(cell_data[0]);
                end
                else
                begin
                    carry_head.valid = accept;
                    count_next       = count_reg + COUNT_WIDTH'(1);
                    if (empty || !out_of_order(item, cell_data[0], order_reg))
                    begin
                        head_next = to_field(item);
                    end
                    else
                    begin
                        head_next = to_field(cell_data[0]);
                    end
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    shift_up   = accept;
                    count_next = count_reg - COUNT_WIDTH'(1);
                    if (count_reg != COUNT_WIDTH'(1))
                    begin
                        head_next = to_field(cell_data[1]);
                    end
                end
            end
            default:
            begin
                // peek, and the unused code
                error_next = empty;
                if (!empty)
                begin
                    head_next = to_field(cell_data[0]);
                end
            end
        endcase
    end

    // Cell chain
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_ctrl_t ctrl;
            carry_t     cin;
            data_t      nbr;

            assign ctrl.shift_up  = shift_up;
            assign ctrl.occupied  = (COUNT_WIDTH'(i) < occ_count);
            assign ctrl.max_first = order_reg;
            assign carry_busy[i]  = carry_out[i].valid;

            if (i == 0)
            begin : g_first
                assign cin = carry_head;
            end
            else
            begin : g_rest
                assign cin = carry_out[i-1];
            end

            if (i < CAPACITY - 1)
            begin : g_inner
                assign nbr = cell_data[i+1];
            end
            else
            begin : g_last
                assign nbr = cell_data[i];
            end

            spq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .carry_in  (cin),
                .next_data (nbr),
                .data      (cell_data[i]),
                .carry_out (carry_out[i])
            );
        end
    endgenerate

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                order_reg <= cfg_data;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_reg      <= head_next;
            out_count_reg <= COUNT_FIELD_WIDTH'(count_next);
            error_reg     <= error_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign head_value = head_reg;
    assign count      = out_count_reg;
    assign error      = error_reg;

    // Checks
    `SPQ_ASSERT_ALWAYS(a_single_carry, $onehot0(carry_busy))
    `SPQ_ASSERT_ALWAYS(a_no_chain_overflow, !carry_out[CAPACITY-1].valid)
    `SPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_WIDTH'(CAPACITY))
    `SPQ_ASSERT_NEXT(a_push_grows, accept && op == OP_PUSH && !full, count_reg == $past(count_reg) + COUNT_WIDTH'(1))
    `SPQ_ASSERT_NEXT(a_error_keeps_count, accept && error_next, count_reg == $past(count_reg))

endmodule

[tb/sorted_priority_queue_tb.sv]
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
    import spq_pkg::*;

    // Opcode 3 has no name in the package; the block treats it as a peek
    localparam logic [OPCODE_WIDTH-1:0] OP_UNUSED = 2'd3;
    // A push carry can still be walking the chain after its result has left
    localparam int SETTLE_CYCLES = CAPACITY + 4;
    localparam int RANDOM_ITEMS = 800;

    typedef struct {
        logic [OPCODE_WIDTH-1:0]       op;
        logic signed [FIELD_WIDTH-1:0] val;
    } queue_op_t;

    typedef struct {
        logic signed [FIELD_WIDTH-1:0] head;
        logic [COUNT_FIELD_WIDTH-1:0]  cnt;
        logic                          err;
    } queue_status_t;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic [OPCODE_WIDTH-1:0]              opcode;
    logic signed [FIELD_WIDTH-1:0]        value;
    logic                                 out_valid;
    logic                                 out_stall;
    logic signed [FIELD_WIDTH-1:0]        head_value;
    logic [COUNT_FIELD_WIDTH-1:0]         count;
    logic                                 error;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic                                 cfg_data;

    // Mirror of the queue contents and the order setting
    data_t         mirror_cells [CAPACITY];
    int            mirror_len;
    logic          mirror_max_first;

    queue_op_t     pending_q[$];
    queue_status_t status_q[$];
    queue_op_t     cur_item;
    int            queued_total;
    int            accepted_total;
    int            gen_len;
    int            gap_left;
    int            stall_left;
    int            failures;
    bit            quiet_in;
    bit            quiet_out;
    queue_status_t want;

    sorted_priority_queue DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .head_value (head_value),
        .count      (count),
        .error      (error),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // a sits behind b under the current order, signed compare
    function automatic bit sits_behind(data_t a, data_t b);
        if (mirror_max_first)
        begin
            return a < b;
        end
        return a > b;
    endfunction

    // Apply one operation to the mirror and return the status it reports
    function automatic queue_status_t predict_status(logic [OPCODE_WIDTH-1:0] op,
                                                     logic signed [FIELD_WIDTH-1:0] v);
        queue_status_t res;
        data_t         tmp;
        res.err = 1'b0;
        if (op == OP_PUSH)
        begin
            if (mirror_len >= CAPACITY)
            begin
                res.err = 1'b1;
            end
            else
            begin
                for (int i = mirror_len; i > 0; i--)
                begin
                    mirror_cells[i] = mirror_cells[i-1];
                end
                mirror_cells[0] = v;
                mirror_len++;
                // single compare-and-swap pass down the chain
                for (int i = 0; i + 1 < mirror_len; i++)
                begin
                    if (sits_behind(mirror_cells[i], mirror_cells[i+1]))
                    begin
                        tmp = mirror_cells[i];
                        mirror_cells[i] = mirror_cells[i+1];
                        mirror_cells[i+1] = tmp;
                    end
                end
            end
        end
        else if (op == OP_POP)
        begin
            if (mirror_len == 0)
            begin
                res.err = 1'b1;
            end
            else
            begin
                for (int i = 0; i + 1 < mirror_len; i++)
                begin
                    mirror_cells[i] = mirror_cells[i+1];
                end
                mirror_len--;
            end
        end
        else
        begin
            res.err = (mirror_len == 0);
        end
        res.head = (mirror_len > 0) ? mirror_cells[0] : '0;
        res.cnt = mirror_len[COUNT_FIELD_WIDTH-1:0];
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Extremes, small clustered values for ties, and full-range noise
    function automatic logic signed [FIELD_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return '0;
            3: return '1;
            4, 5: return $signed($urandom_range(0, 15)) - 8;
            default: return $urandom();
        endcase
    endfunction

    // Queue one item and track the count it will leave behind
    function automatic void queue_item(logic [OPCODE_WIDTH-1:0] op,
                                       logic signed [FIELD_WIDTH-1:0] v);
        queue_op_t it;
        it.op = op;
        it.val = v;
        pending_q.push_back(it);
        queued_total++;
        if (op == OP_PUSH && gen_len < CAPACITY)
        begin
            gen_len++;
        end
        else if (op == OP_POP && gen_len > 0)
        begin
            gen_len--;
        end
    endfunction

    // Wait until every item is through and any carry has settled
    task automatic wait_idle();
        while (accepted_total != queued_total || status_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the order register through its handshake
    task automatic write_order(logic max_first);
        cfg_data <= max_first;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mirror_max_first = max_first;
    endtask

    // Input driver: one item from the pending queue at a time
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                status_q.push_back(predict_status(cur_item.op, cur_item.val));
                accepted_total++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    cur_item = pending_q.pop_front();
                    opcode <= cur_item.op;
                    value <= cur_item.val;
                    in_valid <= 1'b1;
                    gap_left = pick_gap(quiet_in);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                begin
                    $error("result with no item waiting: head_value %0d count %0d error %0d",
                           head_value, count, error);
                    failures++;
                end
                else
                begin
                    want = status_q.pop_front();
                    if (head_value !== want.head)
                    begin
                        $error("head_value: expected %0d, got %0d", want.head, head_value);
                        failures++;
                    end
                    if (count !== want.cnt)
                    begin
                        $error("count: expected %0d, got %0d", want.cnt, count);
                        failures++;
                    end
                    if (error !== want.err)
                    begin
                        $error("error: expected %0d, got %0d", want.err, error);
                        failures++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = pick_gap(quiet_out);
            end
        end
    end

    // Stimulus
    initial
    begin
        int                      rand_items;
        int                      extra;
        int                      r;
        phase_kind_t             kind;
        logic [OPCODE_WIDTH-1:0] op;

        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = '0;
        value = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        mirror_len = 0;
        mirror_max_first = 1'b1;
        queued_total = 0;
        accepted_total = 0;
        gen_len = 0;
        gap_left = 0;
        stall_left = 0;
        failures = 0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        rand_items = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue: pop, peek and the unused opcode all flag an error
        queue_item(OP_POP, 32'sh12345678);
        queue_item(OP_PEEK, '0);
        queue_item(OP_UNUSED, '1);
        // Extremes under max-first order
        queue_item(OP_PUSH, 32'sh7FFFFFFF);
        queue_item(OP_PUSH, 32'sh80000000);
        queue_item(OP_PUSH, '0);
        queue_item(OP_PUSH, '1);
        queue_item(OP_PUSH, 32'sd1);
        queue_item(OP_UNUSED, '0);
        queue_item(OP_PEEK, '1);
        repeat (5) queue_item(OP_POP, '0);
        queue_item(OP_POP, '0);
        wait_idle();

        // Min-first order
        write_order(1'b0);
        queue_item(OP_PUSH, 32'sd100);
        queue_item(OP_PUSH, -32'sd100);
        queue_item(OP_PUSH, '0);
        wait_idle();

        // Order flipped with entries held: no re-sort
        write_order(1'b1);
        queue_item(OP_PUSH, 32'sd50);
        queue_item(OP_PUSH, -32'sd200);
        repeat (4) queue_item(OP_POP, '0);

        // Random phases, order register rewritten between them
        while (rand_items < RANDOM_ITEMS)
        begin
            wait_idle();
            write_order(1'($urandom_range(0, 1)));
            quiet_in = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            kind = phase_kind_t'($urandom_range(0, 2));
            case (kind)
                PH_FILL:
                begin
                    // fill up, then push into a full queue
                    extra = $urandom_range(1, 3);
                    while (extra > 0)
                    begin
                        op = ($urandom_range(0, 6) == 0) ? OP_PEEK : OP_PUSH;
                        if (op == OP_PUSH && gen_len == CAPACITY)
                        begin
                            extra--;
                        end
                        queue_item(op, pick_value());
                        rand_items++;
                    end
                end
                PH_DRAIN:
                begin
                    // drain, then pop an empty queue
                    extra = $urandom_range(1, 2);
                    while (extra > 0)
                    begin
                        r = $urandom_range(0, 9);
                        if (r == 0)
                        begin
                            op = OP_PEEK;
                        end
                        else if (r == 1)
                        begin
                            op = OP_UNUSED;
                        end
                        else
                        begin
                            op = OP_POP;
                        end
                        if (op == OP_POP && gen_len == 0)
                        begin
                            extra--;
                        end
                        queue_item(op, pick_value());
                        rand_items++;
                    end
                end
                default:
                begin
                    repeat ($urandom_range(20, 40))
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 45)
                        begin
                            op = OP_PUSH;
                        end
                        else if (r < 80)
                        begin
                            op = OP_POP;
                        end
                        else if (r < 95)
                        begin
                            op = OP_PEEK;
                        end
                        else
                        begin
                            op = OP_UNUSED;
                        end
                        queue_item(op, pick_value());
                        rand_items++;
                    end
                end
            endcase
        end

        wait_idle();
        if (failures == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
